@@ rtl/gfcs_pkg.sv @@
`default_nettype none
package gfcs_pkg;

    localparam int KEY_BITS_DEF = 6;
    localparam int KEY_CODE_W   = 6;
    localparam int VALUE_W      = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HAS_MAX_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIGNED  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GAP,
        OP_ELEM,
        OP_PAD,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic gap_go;
        logic elem_go;
        logic pad_go;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/gfcs_ctrl.sv @@
`default_nettype none
module gfcs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire gfcs_pkg::status_t status,
    output gfcs_pkg::cmd_t        cmd
);
    import gfcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!status.gap_go && !status.elem_go && !status.pad_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_RUN: begin
                if (status.gap_go) begin
                    cmd.op = status.out_free ? OP_GAP : OP_NONE;
                end else if (status.elem_go) begin
                    cmd.op = status.out_free ? OP_ELEM : OP_NONE;
                end else if (status.pad_go) begin
                    cmd.op = status.out_free ? OP_PAD : OP_NONE;
                end else begin
                    cmd.op = OP_FINISH;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/gfcs_dp.sv @@
`default_nettype none
module gfcs_dp #(
    parameter int KEY_BITS = gfcs_pkg::KEY_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            has_max_key,
    input  wire logic                            key_signed,
    input  wire gfcs_pkg::cmd_t                  cmd,
    output gfcs_pkg::status_t                    status,
    input  wire logic [gfcs_pkg::KEY_CODE_W-1:0] s_elem_key,
    input  wire logic [gfcs_pkg::VALUE_W-1:0]    s_elem_value,
    input  wire logic [gfcs_pkg::KEY_CODE_W-1:0] s_row_max_key,
    input  wire logic                            s_first_in_row,
    input  wire logic                            s_last_in_row,
    input  wire logic                            s_empty_row,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gfcs_pkg::KEY_CODE_W-1:0]      m_out_key,
    output logic [gfcs_pkg::VALUE_W-1:0]         m_sum_out,
    output logic                                 m_last_of_run,
    output logic                                 m_row_end
);
    import gfcs_pkg::*;

    localparam int NK_W = KEY_BITS + 2;

    logic signed [NK_W-1:0]    key_reg, key_next;
    logic signed [NK_W-1:0]    mx_reg, mx_next;
    logic        [VALUE_W-1:0] value_reg, value_next;
    logic                      first_reg, first_next;
    logic                      last_reg, last_next;
    logic                      elem_pend_reg, elem_pend_next;
    logic        [VALUE_W-1:0] sum_reg, sum_next;
    logic signed [NK_W-1:0]    nk_reg, nk_next;
    logic                      row_done_reg, row_done_next;

    logic                      m_valid_reg, m_valid_next;
    logic [KEY_CODE_W-1:0]     m_key_reg, m_key_next;
    logic [VALUE_W-1:0]        m_sum_reg, m_sum_next;
    logic                      m_last_reg, m_last_next;
    logic                      m_row_end_reg, m_row_end_next;

    logic signed [NK_W-1:0]    key_dec, mx_dec, lo, hi_p1, nk_base, nk_inc;
    logic                      in_first, in_last;
    logic                      reach_nk, reach_key;
    logic                      emit, emit_last;
    logic signed [NK_W-1:0]    emit_key;
    logic        [VALUE_W-1:0] emit_sum;

    always_comb begin
        key_dec = {{2{s_elem_key[KEY_BITS-1] & key_signed}}, s_elem_key[KEY_BITS-1:0]};
        mx_dec  = {{2{s_row_max_key[KEY_BITS-1] & key_signed}}, s_row_max_key[KEY_BITS-1:0]};
        lo      = key_signed ? {3'b111, {(KEY_BITS-1){1'b0}}} : '0;
        hi_p1   = key_signed ? {3'b001, {(KEY_BITS-1){1'b0}}} : {2'b01, {KEY_BITS{1'b0}}};
        in_first = s_first_in_row | s_empty_row;
        in_last  = s_last_in_row | s_empty_row;
        nk_base  = in_first ? '0 : nk_reg;
        nk_inc   = nk_reg + NK_W'(1);
        reach_nk  = has_max_key && (nk_reg >= mx_reg);
        reach_key = has_max_key && (key_reg >= mx_reg);
    end

    always_comb begin
        status.gap_go   = elem_pend_reg && !first_reg && !row_done_reg && (nk_reg < key_reg);
        status.elem_go  = elem_pend_reg && !row_done_reg;
        status.pad_go   = last_reg && has_max_key && (nk_reg <= mx_reg);
        status.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        key_next       = key_reg;
        mx_next        = mx_reg;
        value_next     = value_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        elem_pend_next = elem_pend_reg;
        sum_next       = sum_reg;
        nk_next        = nk_reg;
        row_done_next  = row_done_reg;
        emit           = 1'b0;
        emit_last      = 1'b0;
        emit_key       = nk_reg;
        emit_sum       = sum_reg;

        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_GAP: begin
                emit          = 1'b1;
                emit_last     = reach_nk;
                row_done_next = reach_nk;
                nk_next       = nk_inc;
            end
            OP_ELEM: begin
                sum_next       = sum_reg + value_reg;
                emit           = 1'b1;
                emit_key       = key_reg;
                emit_sum       = sum_next;
                emit_last      = !(last_reg && has_max_key && (key_reg < mx_reg));
                nk_next        = key_reg + NK_W'(1);
                row_done_next  = reach_key;
                elem_pend_next = 1'b0;
            end
            OP_PAD: begin
                emit      = 1'b1;
                emit_last = reach_nk;
                nk_next   = nk_inc;
            end
            OP_FINISH: begin
                if (last_reg) begin
                    sum_next      = '0;
                    nk_next       = '0;
                    row_done_next = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (cmd.load) begin
            key_next       = key_dec;
            mx_next        = mx_dec;
            value_next     = s_elem_value;
            first_next     = in_first;
            last_next      = in_last;
            elem_pend_next = !s_empty_row;
            sum_next       = in_first ? '0 : sum_reg;
            row_done_next  = in_first ? 1'b0 : row_done_reg;
            if (nk_base < lo) begin
                nk_next = lo;
            end else if (nk_base > hi_p1) begin
                nk_next = hi_p1;
            end else begin
                nk_next = nk_base;
            end
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_key_next     = m_key_reg;
        m_sum_next     = m_sum_reg;
        m_last_next    = m_last_reg;
        m_row_end_next = m_row_end_reg;
        if (emit) begin
            m_valid_next   = 1'b1;
            m_key_next     = KEY_CODE_W'(emit_key[KEY_BITS-1:0]);
            m_sum_next     = emit_sum;
            m_last_next    = emit_last;
            m_row_end_next = emit_last && last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            nk_reg       <= '0;
            row_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            sum_reg      <= sum_next;
            nk_reg       <= nk_next;
            row_done_reg <= row_done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        mx_reg        <= mx_next;
        value_reg     <= value_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        elem_pend_reg <= elem_pend_next;
        m_key_reg     <= m_key_next;
        m_sum_reg     <= m_sum_next;
        m_last_reg    <= m_last_next;
        m_row_end_reg <= m_row_end_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_key     = m_key_reg;
    assign m_sum_out     = m_sum_reg;
    assign m_last_of_run = m_last_reg;
    assign m_row_end     = m_row_end_reg;

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result written over an untaken transfer");

    a_last_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_last) |=> (cmd.op == OP_FINISH))
        else $error("result flagged last but more results follow");

    a_row_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FINISH && last_reg) |=>
            (sum_reg == '0 && nk_reg == '0 && !row_done_reg))
        else $error("row state not cleared at row end");

endmodule
`default_nettype wire

@@ rtl/gap_filling_cumulative_sum_top.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------------
// input    | s_valid / s_ready  | s_elem_key, s_elem_value, s_row_max_key,
//          |                    | s_first_in_row, s_last_in_row, s_empty_row
// result   | m_valid / m_ready  | m_out_key, m_sum_out, m_last_of_run, m_row_end
// config   | cfg_we             | cfg_idx, cfg_wdata
//
// An item is handled as one load step, then one result per cycle while the result
// register is free, then one closing step; an item may give no result at all.
// s_ready is high only while the sequencer is idle.
// A stalled result register holds the sequencer until the transfer completes.
// Synchronous active-low reset clears sums, key tracker and configuration.
`default_nettype none
module gap_filling_cumulative_sum_top #(
    parameter int KEY_BITS = gfcs_pkg::KEY_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [gfcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [gfcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [gfcs_pkg::KEY_CODE_W-1:0] s_elem_key,
    input  wire logic [gfcs_pkg::VALUE_W-1:0]    s_elem_value,
    input  wire logic [gfcs_pkg::KEY_CODE_W-1:0] s_row_max_key,
    input  wire logic                            s_first_in_row,
    input  wire logic                            s_last_in_row,
    input  wire logic                            s_empty_row,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gfcs_pkg::KEY_CODE_W-1:0]      m_out_key,
    output logic [gfcs_pkg::VALUE_W-1:0]         m_sum_out,
    output logic                                 m_last_of_run,
    output logic                                 m_row_end
);
    import gfcs_pkg::*;

    logic    has_max_key_reg, has_max_key_next;
    logic    key_signed_reg, key_signed_next;
    cmd_t    cmd;
    status_t status;

    always_comb begin
        has_max_key_next = has_max_key_reg;
        key_signed_next  = key_signed_reg;
        if (cfg_we) begin
            unique case (cfg_idx)
                CFG_HAS_MAX_KEY: has_max_key_next = cfg_wdata[0];
                CFG_KEY_SIGNED:  key_signed_next  = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_max_key_reg <= 1'b0;
            key_signed_reg  <= 1'b0;
        end else begin
            has_max_key_reg <= has_max_key_next;
            key_signed_reg  <= key_signed_next;
        end
    end

    gfcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gfcs_dp #(
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .has_max_key    (has_max_key_reg),
        .key_signed     (key_signed_reg),
        .cmd            (cmd),
        .status         (status),
        .s_elem_key     (s_elem_key),
        .s_elem_value   (s_elem_value),
        .s_row_max_key  (s_row_max_key),
        .s_first_in_row (s_first_in_row),
        .s_last_in_row  (s_last_in_row),
        .s_empty_row    (s_empty_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_key      (m_out_key),
        .m_sum_out      (m_sum_out),
        .m_last_of_run  (m_last_of_run),
        .m_row_end      (m_row_end)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_gap_filling_cumulative_sum_top.sv @@
module tb_gap_filling_cumulative_sum_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KB            = gfcs_pkg::KEY_BITS_DEF;
    localparam int MAX_RUN       = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [gfcs_pkg::KEY_CODE_W-1:0] key;
        logic [gfcs_pkg::VALUE_W-1:0]    value;
        logic [gfcs_pkg::KEY_CODE_W-1:0] max_key;
        logic                            is_first;
        logic                            is_last;
        logic                            is_empty;
    } row_item_t;

    typedef struct packed {
        logic [gfcs_pkg::KEY_CODE_W-1:0] key;
        logic [gfcs_pkg::VALUE_W-1:0]    sum;
        logic                            last_of_run;
        logic                            row_end;
    } sum_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [gfcs_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [gfcs_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [gfcs_pkg::KEY_CODE_W-1:0] s_elem_key;
    logic [gfcs_pkg::VALUE_W-1:0]    s_elem_value;
    logic [gfcs_pkg::KEY_CODE_W-1:0] s_row_max_key;
    logic                            s_first_in_row;
    logic                            s_last_in_row;
    logic                            s_empty_row;
    logic                            m_valid;
    logic                            m_ready;
    logic [gfcs_pkg::KEY_CODE_W-1:0] m_out_key;
    logic [gfcs_pkg::VALUE_W-1:0]    m_sum_out;
    logic                            m_last_of_run;
    logic                            m_row_end;

    sum_result_t       expected_sums[$];
    logic [63:0]       acc_sum;
    int                next_key;
    bit                row_closed;
    bit                max_en;
    bit                signed_keys;
    int                run_count;
    int                error_count = 0;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_req;
    int                hold_left;
    int                stall_cycles = 0;

    gap_filling_cumulative_sum_top #(
        .KEY_BITS(KB)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_elem_key    (s_elem_key),
        .s_elem_value  (s_elem_value),
        .s_row_max_key (s_row_max_key),
        .s_first_in_row(s_first_in_row),
        .s_last_in_row (s_last_in_row),
        .s_empty_row   (s_empty_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_key     (m_out_key),
        .m_sum_out     (m_sum_out),
        .m_last_of_run (m_last_of_run),
        .m_row_end     (m_row_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int key_value(logic [gfcs_pkg::KEY_CODE_W-1:0] code);
        logic [gfcs_pkg::KEY_CODE_W-1:0] c;
        c = code & gfcs_pkg::KEY_CODE_W'((1 << KB) - 1);
        if (signed_keys && c[KB-1]) begin
            return int'(c) - (1 << KB);
        end
        return int'(c);
    endfunction

    function automatic void emit_sum(int key);
        sum_result_t r;
        if (run_count >= MAX_RUN) begin
            return;
        end
        r.key         = gfcs_pkg::KEY_CODE_W'(key) & gfcs_pkg::KEY_CODE_W'((1 << KB) - 1);
        r.sum         = acc_sum;
        r.last_of_run = 1'b0;
        r.row_end     = 1'b0;
        expected_sums.insert(expected_sums.size(), r);
        run_count++;
    endfunction

    function automatic void predict_sums(row_item_t it);
        int          lo;
        int          hi;
        int          k;
        int          mx;
        bit          opens;
        bit          closes;
        sum_result_t r;
        lo        = signed_keys ? -(1 << (KB - 1)) : 0;
        hi        = signed_keys ? (1 << (KB - 1)) - 1 : (1 << KB) - 1;
        opens     = it.is_first || it.is_empty;
        closes    = it.is_last || it.is_empty;
        k         = key_value(it.key);
        mx        = key_value(it.max_key);
        run_count = 0;
        if (opens) begin
            acc_sum    = '0;
            next_key   = 0;
            row_closed = 1'b0;
        end
        if (next_key < lo) next_key = lo;
        if (next_key > hi + 1) next_key = hi + 1;
        if (!it.is_empty && !row_closed) begin
            if (!opens) begin
                while (!row_closed && next_key < k) begin
                    emit_sum(next_key);
                    row_closed = max_en && next_key >= mx;
                    next_key++;
                end
            end
            if (!row_closed) begin
                acc_sum = acc_sum + it.value;
                emit_sum(k);
                next_key   = k + 1;
                row_closed = max_en && k >= mx;
            end
        end
        if (closes && max_en) begin
            while (next_key <= mx) begin
                emit_sum(next_key);
                next_key++;
            end
        end
        if (run_count > 0) begin
            r             = expected_sums.pop_back();
            r.last_of_run = 1'b1;
            r.row_end     = closes;
            expected_sums.insert(expected_sums.size(), r);
        end
        if (closes) begin
            acc_sum    = '0;
            next_key   = 0;
            row_closed = 1'b0;
        end
    endfunction

    function automatic row_item_t mk_item(int key, logic [63:0] value, int max_key,
                                          bit is_first, bit is_last, bit is_empty);
        row_item_t it;
        it.key      = gfcs_pkg::KEY_CODE_W'(key);
        it.value    = value;
        it.max_key  = gfcs_pkg::KEY_CODE_W'(max_key);
        it.is_first = is_first;
        it.is_last  = is_last;
        it.is_empty = is_empty;
        return it;
    endfunction

    function automatic logic [63:0] rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            case ($urandom_range(3))
                0: return 64'h7FFF_FFFF_FFFF_FFFF;
                1: return 64'h8000_0000_0000_0000;
                2: return 64'hFFFF_FFFF_FFFF_FFFF;
                default: return 64'h0;
            endcase
        end
        if (pick < 30) begin
            return {{32{pick[0]}}, 32'($urandom_range(1000))};
        end
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(logic [gfcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [gfcs_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        @(posedge aclk);
        case (idx)
            gfcs_pkg::CFG_HAS_MAX_KEY: max_en      = data[0];
            gfcs_pkg::CFG_KEY_SIGNED:  signed_keys = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(row_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_elem_key     = it.key;
        s_elem_value   = it.value;
        s_row_max_key  = it.max_key;
        s_first_in_row = it.is_first;
        s_last_in_row  = it.is_last;
        s_empty_row    = it.is_empty;
        s_valid        = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        predict_sums(it);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic run_random_rows(int n_items);
        int        sent;
        int        len;
        int        lo;
        int        hi;
        int        k;
        int        mx;
        int        pick;
        bit        open_row;
        bit        close_row;
        row_item_t it;
        sent = 0;
        while (sent < n_items) begin
            lo   = signed_keys ? -(1 << (KB - 1)) : 0;
            hi   = signed_keys ? (1 << (KB - 1)) - 1 : (1 << KB) - 1;
            pick = $urandom_range(99);
            if (pick < 16) begin
                it = mk_item($urandom_range(63), rand_value(), $urandom_range(63),
                             1'($urandom_range(1)), 1'($urandom_range(1)), pick < 8);
                send_item(it);
                sent++;
            end else begin
                len       = $urandom_range(1, 6);
                mx        = lo + $urandom_range(hi - lo);
                k         = lo + $urandom_range(hi - lo);
                open_row  = ($urandom_range(9) != 0);
                close_row = ($urandom_range(9) != 0);
                if ($urandom_range(1)) k = lo + $urandom_range(4);
                for (int i = 0; i < len; i++) begin
                    if (i > 0) begin
                        pick = $urandom_range(99);
                        if (pick < 8) k = k - $urandom_range(6);
                        else if (pick < 18) k = k + $urandom_range(20);
                        else k = k + $urandom_range(1, 3);
                        if (k > hi) k = hi;
                        if (k < lo) k = lo;
                    end
                    if ($urandom_range(9) == 0) mx = lo + $urandom_range(hi - lo);
                    it = mk_item(k, rand_value(), mx, open_row && i == 0,
                                 close_row && i == len - 1, 1'b0);
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_plain_rows();
        send_item(mk_item(0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 0, 0));
        send_item(mk_item(3, 64'd1, 0, 0, 0, 0));
        send_item(mk_item(63, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
        send_item(mk_item(10, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 0));
        send_item(mk_item(5, 64'd0, 63, 0, 0, 1));
        send_item(mk_item(2, 64'd5, 0, 0, 0, 0));
        send_item(mk_item(2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 0));
        wait_idle();
    endtask

    task automatic test_max_key_rows();
        write_reg(gfcs_pkg::CFG_HAS_MAX_KEY, 1'b1);
        send_item(mk_item(1, 64'd10, 5, 1, 0, 0));
        send_item(mk_item(7, 64'd20, 5, 0, 0, 0));
        send_item(mk_item(8, 64'd30, 5, 0, 0, 0));
        send_item(mk_item(9, 64'd40, 5, 0, 1, 0));
        send_item(mk_item(0, 64'd0, 63, 0, 0, 1));
        send_item(mk_item(3, 64'd7, 0, 1, 1, 0));
        send_item(mk_item(0, 64'd9, 4, 1, 1, 0));
        send_item(mk_item(0, 64'd0, 0, 1, 0, 0));
        send_item(mk_item(2, 64'd1, 3, 0, 1, 0));
        wait_idle();
    endtask

    task automatic test_signed_keys();
        write_reg(gfcs_pkg::CFG_KEY_SIGNED, 1'b1);
        send_item(mk_item(0, 64'd0, -1, 1, 1, 1));
        send_item(mk_item(-32, 64'd1, -28, 1, 0, 0));
        send_item(mk_item(-30, 64'd2, -28, 0, 1, 0));
        send_item(mk_item(-5, 64'd3, 31, 1, 0, 0));
        wait_idle();
        // row stays open across the mode switch; tracker clamps into unsigned range
        write_reg(gfcs_pkg::CFG_KEY_SIGNED, 1'b0);
        send_item(mk_item(4, 64'd1, 63, 0, 1, 0));
        send_item(mk_item(63, 64'd6, 63, 1, 0, 0));
        wait_idle();
        write_reg(gfcs_pkg::CFG_KEY_SIGNED, 1'b1);
        write_reg(gfcs_pkg::CFG_HAS_MAX_KEY, 1'b0);
        send_item(mk_item(-3, 64'd2, 0, 0, 1, 0));
        wait_idle();
    endtask

    task automatic test_random_rows();
        set_idling(0, 0);
        write_reg(gfcs_pkg::CFG_KEY_SIGNED, 1'b0);
        run_random_rows(60);
        wait_idle();
        set_idling(70, 0);
        write_reg(gfcs_pkg::CFG_HAS_MAX_KEY, 1'b1);
        run_random_rows(60);
        wait_idle();
        set_idling(0, 70);
        write_reg(gfcs_pkg::CFG_KEY_SIGNED, 1'b1);
        run_random_rows(60);
        wait_idle();
        set_idling(8, 8);
        write_reg(gfcs_pkg::CFG_HAS_MAX_KEY, 1'b0);
        run_random_rows(60);
        wait_idle();
    endtask

    task automatic test_result_backpressure();
        set_idling(0, 0);
        write_reg(gfcs_pkg::CFG_HAS_MAX_KEY, 1'b1);
        write_reg(gfcs_pkg::CFG_KEY_SIGNED, 1'b0);
        hold_req = 200;
        run_random_rows(20);
        wait_idle();
    endtask

    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_sums
        sum_result_t got;
        sum_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.key         = m_out_key;
            got.sum         = m_sum_out;
            got.last_of_run = m_last_of_run;
            got.row_end     = m_row_end;
            if (expected_sums.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: key %0d sum %h last_of_run %b row_end %b",
                             got.key, got.sum, got.last_of_run, got.row_end);
                end
            end else begin
                want = expected_sums.pop_front();
                if (got.key !== want.key || got.sum !== want.sum ||
                    got.last_of_run !== want.last_of_run || got.row_end !== want.row_end) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected key %0d sum %h lor %b re %b",
                                 want.key, want.sum, want.last_of_run, want.row_end);
                        $display("          actual   key %0d sum %h lor %b re %b",
                                 got.key, got.sum, got.last_of_run, got.row_end);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_elem_key     = '0;
        s_elem_value   = '0;
        s_row_max_key  = '0;
        s_first_in_row = 1'b0;
        s_last_in_row  = 1'b0;
        s_empty_row    = 1'b0;
        acc_sum        = '0;
        next_key       = 0;
        row_closed     = 1'b0;
        max_en         = 1'b0;
        signed_keys    = 1'b0;
        hold_req       = 0;
        set_idling(0, 0);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_plain_rows();
        test_max_key_rows();
        test_signed_keys();
        test_random_rows();
        test_result_backpressure();
        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
